// ----- src/ack_retry_signal_and_ping_link_assert.svh -----
// Assertion macros shared by the link controller RTL.
`ifndef ACK_RETRY_SIGNAL_AND_PING_LINK_ASSERT_SVH
`define ACK_RETRY_SIGNAL_AND_PING_LINK_ASSERT_SVH

// Same-cycle implication, checked on clk outside reset.
`define ARSP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define ARSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/arsp_pkg.sv -----
// Types, constants and register map of the signal and ping link controller.
package arsp_pkg;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [2:0] {
		REG_LINK_ADDR  = 3'd0,
		REG_PING_IVL   = 3'd1,
		REG_IDLE_LIMIT = 3'd2,
		REG_LOCKOUT    = 3'd3,
		REG_FLASH      = 3'd4,
		REG_ATTEMPTS   = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_SIGNAL = 2'd1,
		PH_PING   = 2'd2
	} phase_t;

	localparam logic [7:0] CMD_SIG      = 8'd208;
	localparam logic [7:0] CMD_SIG_OK   = 8'd209;
	localparam logic [7:0] CMD_PROBE    = 8'd212;
	localparam logic [7:0] CMD_PROBE_OK = 8'd213;
	localparam logic [7:0] CMD_NONE     = 8'd0;
	localparam logic [7:0] PKT_LEN      = 8'd3;

	localparam logic [1:0] FLASH_NONE = 2'd0;
	localparam logic [1:0] FLASH_FAIL = 2'd1;
	localparam logic [1:0] FLASH_IDLE = 2'd2;

	localparam logic [15:0] RT_RESET = 16'd300;

	localparam logic [7:0]  LINK_ADDR_RST  = 8'd4;
	localparam logic [15:0] PING_IVL_RST   = 16'd3000;
	localparam logic [21:0] IDLE_LIMIT_RST = 22'd3600000;
	localparam logic [9:0]  LOCKOUT_RST    = 10'd100;
	localparam logic [9:0]  FLASH_RST      = 10'd100;
	localparam logic [3:0]  ATTEMPTS_RST   = 4'd3;

	typedef struct packed {
		logic [7:0]  link_address;
		logic [15:0] ping_interval_ms;
		logic [21:0] idle_limit_ms;
		logic [9:0]  lockout_ms;
		logic [9:0]  flash_ms;
		logic [3:0]  attempts;
	} cfg_t;

	typedef struct packed {
		logic       button_pressed;
		logic       packet_valid;
		logic [7:0] packet_length;
		logic [7:0] packet_address;
		logic [7:0] packet_command;
	} pkt_t;

	typedef struct packed {
		logic        send_valid;
		logic [7:0]  send_command;
		logic        send_data;
		logic        status_led;
		logic        big_led;
		logic [1:0]  flash_request;
		logic [15:0] round_trip_ms;
	} res_t;

endpackage

// ----- src/arsp_regs.sv -----
// APB configuration registers of the link controller.
module arsp_regs import arsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.link_address     <= LINK_ADDR_RST;
			cfg_q.ping_interval_ms <= PING_IVL_RST;
			cfg_q.idle_limit_ms    <= IDLE_LIMIT_RST;
			cfg_q.lockout_ms       <= LOCKOUT_RST;
			cfg_q.flash_ms         <= FLASH_RST;
			cfg_q.attempts         <= ATTEMPTS_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_LINK_ADDR:  cfg_q.link_address     <= pwdata[7:0];
				REG_PING_IVL:   cfg_q.ping_interval_ms <= pwdata[15:0];
				REG_IDLE_LIMIT: cfg_q.idle_limit_ms    <= pwdata[21:0];
				REG_LOCKOUT:    cfg_q.lockout_ms       <= pwdata[9:0];
				REG_FLASH:      cfg_q.flash_ms         <= pwdata[9:0];
				REG_ATTEMPTS:   cfg_q.attempts         <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LINK_ADDR:  prdata = {24'd0, cfg_q.link_address};
			REG_PING_IVL:   prdata = {16'd0, cfg_q.ping_interval_ms};
			REG_IDLE_LIMIT: prdata = {10'd0, cfg_q.idle_limit_ms};
			REG_LOCKOUT:    prdata = {22'd0, cfg_q.lockout_ms};
			REG_FLASH:      prdata = {22'd0, cfg_q.flash_ms};
			REG_ATTEMPTS:   prdata = {28'd0, cfg_q.attempts};
			default:        prdata = '0;
		endcase
	end

endmodule

// ----- src/arsp_core.sv -----
// Session state of the link controller and the per-tick update logic.
module arsp_core import arsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  cfg_t cfg,
	input  pkt_t pkt,
	output res_t res
);

	phase_t      phase_q, phase_d;
	logic        armed_q, armed_d;
	logic        btn_q, btn_d;
	logic [21:0] sb_q, sb_d;
	logic [16:0] sp_q, sp_d;
	logic [19:0] ss_q, ss_d;
	logic        fa_q, fa_d;
	logic [9:0]  fe_q, fe_d;
	logic [3:0]  al_q, al_d;
	logic        rs_q, rs_d;
	logic [7:0]  exp_q, exp_d;
	logic [15:0] rt_q, rt_d;
	logic        lst_q, lst_d;
	logic        lbig_q, lbig_d;
	logic [18:0] window;
	logic [3:0]  first_left;

	assign first_left = (cfg.attempts != 4'd0) ? cfg.attempts - 4'd1 : 4'd0;

	always_comb begin
		phase_d = phase_q; armed_d = armed_q; btn_d = btn_q;
		fa_d = fa_q; fe_d = fe_q; al_d = al_q; rs_d = rs_q;
		exp_d = exp_q; rt_d = rt_q; lst_d = lst_q; lbig_d = lbig_q;
		window = '0;
		res.send_valid    = 1'b0;
		res.send_command  = CMD_NONE;
		res.send_data     = 1'b0;
		res.flash_request = FLASH_NONE;

		sb_d = (sb_q == '1) ? sb_q : sb_q + 22'd1;
		sp_d = (sp_q == '1) ? sp_q : sp_q + 17'd1;
		ss_d = (ss_q == '1) ? ss_q : ss_q + 20'd1;

		if (pkt.packet_valid && pkt.packet_length == PKT_LEN &&
		    pkt.packet_address == cfg.link_address && pkt.packet_command == exp_q) begin
			rt_d = (ss_d > 20'hFFFF) ? 16'hFFFF : ss_d[15:0];
			rs_d = 1'b1;
		end

		if (phase_q != PH_IDLE) begin
			// Reply window: twice the round trip for a signal, five times for a ping.
			window = (phase_q == PH_SIGNAL) ? {2'b0, rt_d, 1'b0}
			                                : {1'b0, rt_d, 2'b0} + {3'b0, rt_d};
			if (rs_d) begin
				if (phase_q == PH_SIGNAL) begin
					lst_d = 1'b1; lbig_d = 1'b1;
				end else begin
					lst_d = ~btn_q;
					fa_d = 1'b1; fe_d = '0;
				end
				phase_d = PH_IDLE;
				sp_d = '0;
			end else if (ss_d >= {1'b0, window}) begin
				if (al_q != 4'd0) begin
					al_d = al_q - 4'd1;
					res.send_valid   = 1'b1;
					res.send_command = (phase_q == PH_SIGNAL) ? CMD_SIG : CMD_PROBE;
					res.send_data    = (phase_q == PH_SIGNAL) ? 1'b1 : btn_q;
					ss_d = '0;
				end else begin
					if (phase_q == PH_SIGNAL) lbig_d = 1'b0;
					lst_d = 1'b0;
					res.flash_request = FLASH_FAIL;
					phase_d = PH_IDLE;
					sp_d = '0;
				end
			end
		end else begin
			if (sb_d > {12'd0, cfg.lockout_ms} && pkt.button_pressed != btn_q) begin
				btn_d = pkt.button_pressed;
				sb_d = '0;
				sp_d = '0;
				armed_d = 1'b1;
				res.send_valid   = 1'b1;
				res.send_command = CMD_SIG;
				res.send_data    = pkt.button_pressed;
				ss_d = '0;
				if (pkt.button_pressed) begin
					phase_d = PH_SIGNAL;
					exp_d = CMD_SIG_OK;
					rs_d = 1'b0;
					al_d = first_left;
				end else begin
					lst_d = 1'b0; lbig_d = 1'b0;
				end
			end
			if (phase_d == PH_IDLE && armed_d) begin
				if (fa_d) begin
					if (fe_d >= cfg.flash_ms) begin
						fa_d = 1'b0;
						lst_d = btn_d;
					end else begin
						fe_d = fe_d + 10'd1;
					end
				end else if (sp_d > {1'b0, cfg.ping_interval_ms}) begin
					phase_d = PH_PING;
					exp_d = CMD_PROBE_OK;
					rs_d = 1'b0;
					al_d = first_left;
					sp_d = '0;
					res.send_valid   = 1'b1;
					res.send_command = CMD_PROBE;
					res.send_data    = btn_d;
					ss_d = '0;
				end
			end
		end

		// An idle stop takes precedence over a failure report in the same tick.
		if (phase_d == PH_IDLE && armed_d && sb_d > cfg.idle_limit_ms) begin
			res.flash_request = FLASH_IDLE;
			armed_d = 1'b0;
			fa_d = 1'b0;
			lst_d = 1'b0;
		end

		res.status_led    = lst_d;
		res.big_led       = lbig_d;
		res.round_trip_ms = rt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; armed_q <= 1'b0; btn_q <= 1'b0;
			sb_q <= '0; sp_q <= '0; ss_q <= '0;
			fa_q <= 1'b0; fe_q <= '0; al_q <= '0; rs_q <= 1'b0;
			exp_q <= CMD_PROBE_OK; rt_q <= RT_RESET;
			lst_q <= 1'b0; lbig_q <= 1'b0;
		end else if (adv) begin
			phase_q <= phase_d; armed_q <= armed_d; btn_q <= btn_d;
			sb_q <= sb_d; sp_q <= sp_d; ss_q <= ss_d;
			fa_q <= fa_d; fe_q <= fe_d; al_q <= al_d; rs_q <= rs_d;
			exp_q <= exp_d; rt_q <= rt_d;
			lst_q <= lst_d; lbig_q <= lbig_d;
		end
	end

endmodule

// ----- src/ack_retry_signal_and_ping_link.sv -----
// Top level of the signal and ping link controller: input and result registers.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | button and received packet of one tick
//  out     | output    | out_valid / out_stall| transmit request, LEDs, flash, round trip
//  cfg     | input     | APB psel / penable   | six configuration registers
//
// Each tick passes an input register and combinational update logic into a result
// register, so one transaction is taken every cycle unless out_stall holds a valid
// result. The result register is held under out_stall; the input register then fills
// and in_stall rises. Reset clears all session state and loads the register defaults;
// no clearing pass is needed.
module ack_retry_signal_and_ping_link import arsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              button_pressed,
	input  logic              packet_valid,
	input  logic [7:0]        packet_length,
	input  logic [7:0]        packet_address,
	input  logic [7:0]        packet_command,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              send_valid,
	output logic [7:0]        send_command,
	output logic              send_data,
	output logic              status_led,
	output logic              big_led,
	output logic [1:0]        flash_request,
	output logic [15:0]       round_trip_ms
);

	`include "ack_retry_signal_and_ping_link_assert.svh"

	cfg_t cfg;
	pkt_t pkt_s1;
	res_t res, res_s2;
	logic valid_s1, valid_s2;
	logic adv_s1, in_acc;

	arsp_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	arsp_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv_s1),
		.cfg   (cfg),
		.pkt   (pkt_s1),
		.res   (res)
	);

	assign adv_s1   = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~adv_s1;
	assign in_acc   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_acc) valid_s1 <= 1'b1;
			else if (adv_s1) valid_s1 <= 1'b0;
			if (adv_s1) valid_s2 <= 1'b1;
			else if (!out_stall) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pkt_s1.button_pressed <= button_pressed;
			pkt_s1.packet_valid   <= packet_valid;
			pkt_s1.packet_length  <= packet_length;
			pkt_s1.packet_address <= packet_address;
			pkt_s1.packet_command <= packet_command;
		end
		if (adv_s1) res_s2 <= res;
	end

	assign out_valid     = valid_s2;
	assign send_valid    = res_s2.send_valid;
	assign send_command  = res_s2.send_command;
	assign send_data     = res_s2.send_data;
	assign status_led    = res_s2.status_led;
	assign big_led       = res_s2.big_led;
	assign flash_request = res_s2.flash_request;
	assign round_trip_ms = res_s2.round_trip_ms;

	`ARSP_ASSERT_NOW(a_cmd_code, valid_s2 && send_valid,
		send_command == CMD_SIG || send_command == CMD_PROBE, "bad transmit command")
	`ARSP_ASSERT_NOW(a_quiet_tx, valid_s2 && !send_valid,
		send_command == CMD_NONE && send_data == 1'b0, "payload without transmit")
	`ARSP_ASSERT_NOW(a_stall_full, in_stall, valid_s1 && valid_s2 && out_stall,
		"input stalled without a blocked result")
	`ARSP_ASSERT_NEXT(a_flash_code, adv_s1,
		flash_request != 2'd3, "undefined flash request")

endmodule
